FILE: rtl/core/spfl_pkg.sv
package spfl_pkg;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [3:0]  slot_index;
      logic [31:0] write_data;
      logic        has_data;
   } req_type;

   typedef struct packed {
      logic [3:0]  granted_index;
      logic [31:0] read_data;
      logic [1:0]  status;
      logic [4:0]  used_count;
   } rsp_type;

   typedef struct packed {
      logic       alloc_ok;
      logic       free_ok;
      logic [1:0] status;
   } ring_status_type;

   typedef struct packed {
      logic write_en;
      logic clear_en;
   } store_cmd_type;

endpackage

FILE: rtl/core/spfl_ram.sv
module spfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/spfl_ring.sv
module spfl_ring
   import spfl_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [1:0]                 operation,
   input  logic [$clog2(SLOTS)-1:0]   free_index,
   output ring_status_type            decision,
   output logic [$clog2(SLOTS+1)-1:0] used_next,
   output logic [$clog2(SLOTS)-1:0]   grant_slot
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);

   logic [IW-1:0] take_ff, take_in;
   logic [IW-1:0] ret_ff, ret_in;
   logic          wrapped_ff, wrapped_in;
   logic [CW-1:0] in_use_ff, in_use_in;
   logic          rd_written_ff, rd_written_in;
   logic [IW-1:0] rd_default_ff, rd_default_in;
   logic          alloc_ok, free_ok;
   logic [IW-1:0] ring_q;

   always_comb begin
      alloc_ok = (operation == OP_ALLOC) && (in_use_ff != CW'(SLOTS));
      free_ok  = (operation == OP_FREE) && (in_use_ff != '0);
      decision.alloc_ok = alloc_ok;
      decision.free_ok  = free_ok;
      if ((operation == OP_ALLOC) && !alloc_ok) begin
         decision.status = ST_FULL;
      end else if ((operation == OP_FREE) && !free_ok) begin
         decision.status = ST_EMPTY;
      end else begin
         decision.status = ST_OK;
      end
   end

   always_comb begin
      take_in       = take_ff;
      ret_in        = ret_ff;
      wrapped_in    = wrapped_ff;
      in_use_in     = in_use_ff;
      rd_written_in = rd_written_ff;
      rd_default_in = rd_default_ff;
      if (accept && alloc_ok) begin
         take_in       = (take_ff == IW'(SLOTS - 1)) ? '0 : take_ff + 1'b1;
         in_use_in     = in_use_ff + 1'b1;
         // entries past the return pointer on the first lap still hold their reset index
         rd_written_in = wrapped_ff || (take_ff < ret_ff);
         rd_default_in = take_ff;
      end
      if (accept && free_ok) begin
         ret_in     = (ret_ff == IW'(SLOTS - 1)) ? '0 : ret_ff + 1'b1;
         wrapped_in = wrapped_ff || (ret_ff == IW'(SLOTS - 1));
         in_use_in  = in_use_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         take_ff       <= '0;
         ret_ff        <= '0;
         wrapped_ff    <= 1'b0;
         in_use_ff     <= '0;
         rd_written_ff <= 1'b0;
         rd_default_ff <= '0;
      end else begin
         take_ff       <= take_in;
         ret_ff        <= ret_in;
         wrapped_ff    <= wrapped_in;
         in_use_ff     <= in_use_in;
         rd_written_ff <= rd_written_in;
         rd_default_ff <= rd_default_in;
      end
   end

   spfl_ram #(
      .WIDTH (IW),
      .DEPTH (SLOTS)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (accept && free_ok),
      .wr_addr (ret_ff),
      .wr_data (free_index),
      .rd_en   (accept && alloc_ok),
      .rd_addr (take_ff),
      .rd_data (ring_q)
   );

   assign used_next  = in_use_in;
   assign grant_slot = rd_written_ff ? ring_q : rd_default_ff;

endmodule

FILE: rtl/core/spfl_slot_store.sv
module spfl_slot_store
   import spfl_pkg::*;
#(
   parameter int SLOTS     = 16,
   parameter int SLOT_BITS = 32,
   parameter int STORE_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  store_cmd_type                  cmd,
   input  logic [$clog2(SLOTS)-1:0]       write_slot,
   input  logic [SLOT_BITS-1:0]           write_word,
   input  logic [$clog2(STORE_DEPTH)-1:0] access_idx,
   output logic [31:0]                    read_word
);

   localparam int IW  = $clog2(SLOTS);
   localparam int SDW = $clog2(STORE_DEPTH);
   localparam bit FULL_DEPTH = (STORE_DEPTH == SLOTS);

   logic [SLOT_BITS-1:0]    data_ff [STORE_DEPTH];
   logic [STORE_DEPTH-1:0]  valid_ff;
   logic                    in_range;
   logic [SDW-1:0]          write_addr;
   logic [SLOT_BITS-1:0]    rd_full;
   logic [SLOT_BITS+31:0]   rd_ext;

   // slots above the store depth can never be freed or read, so writes there are dropped
   assign in_range   = FULL_DEPTH || ({1'b0, write_slot} < (IW + 1)'(STORE_DEPTH));
   assign write_addr = write_slot[SDW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.write_en && in_range) begin
         valid_ff[write_addr] <= 1'b1;
      end else if (cmd.clear_en) begin
         valid_ff[access_idx] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_en && in_range) begin
         data_ff[write_addr] <= write_word;
      end
   end

   assign rd_full   = valid_ff[access_idx] ? data_ff[access_idx] : '0;
   assign rd_ext    = {32'b0, rd_full};
   assign read_word = rd_ext[31:0];

endmodule

FILE: rtl/core/slot_pool_free_list.sv
// Slot pool with a circular free list of slot indices.
// Requests enter on req_valid/req_ready, responses leave on rsp_valid/rsp_ready,
// one response per request, in request order.
// Allocate pops the next index off the ring, stores the word (or zero) in that
// slot and returns the index; free pushes an index back and clears its slot;
// read returns a slot's contents. Allocate on a full pool and free on an empty
// pool are refused with a status and change nothing.
// The request is registered in the middle stage, then in the response register.
// Throughput: one request per cycle unless the receiver stalls; the ring memory
// is read at acceptance and its registered output feeds the slot write when
// the middle stage advances.
// Reset clears the pointers and the use count at once; untouched ring entries
// read back their own index and untouched slots read zero, so requests are
// taken from the first cycle after reset.
// When the receiver stalls, the response register holds its value and one more
// request can sit in the middle stage; req_ready drops only when both are full.
module slot_pool_free_list
   import spfl_pkg::*;
#(
   parameter int SLOTS     = 16,
   parameter int SLOT_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IW  = $clog2(SLOTS);
   localparam int CW  = $clog2(SLOTS + 1);
   localparam int SD  = (SLOTS < 16) ? SLOTS : 16;
   localparam int SDW = $clog2(SD);

   logic                  accept;
   logic                  s1_advance;
   logic [SDW-1:0]        idx_sd;
   logic [IW-1:0]         idx_ring;
   ring_status_type       decision;
   logic [CW-1:0]         used_next;
   logic [CW+4:0]         used_ext;
   logic [IW-1:0]         grant_slot;
   logic [IW+3:0]         slot_ext;
   logic [SLOT_BITS+31:0] wd_ext;
   store_cmd_type         store_cmd;
   logic [31:0]           read_word;

   logic                 s1_valid_ff, s1_valid_in;
   logic [1:0]           s1_op_ff;
   logic [SDW-1:0]       s1_idx_ff;
   logic [SLOT_BITS-1:0] s1_word_ff;
   ring_status_type      s1_dec_ff;
   logic [4:0]           s1_used_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign accept     = req_valid && req_ready;

   // fold the incoming index into the pool
   always_comb begin
      idx_sd = '0;
      for (int i = 0; i < 16; i++) begin
         if (req_data.slot_index == 4'(i)) begin
            idx_sd = SDW'(i % SLOTS);
         end
      end
   end

   assign idx_ring = IW'(idx_sd);
   assign used_ext = {5'b0, used_next};
   assign wd_ext   = {{SLOT_BITS{1'b0}}, req_data.write_data};

   spfl_ring #(
      .SLOTS (SLOTS)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .operation  (req_data.operation),
      .free_index (idx_ring),
      .decision   (decision),
      .used_next  (used_next),
      .grant_slot (grant_slot)
   );

   assign s1_valid_in = accept || (s1_valid_ff && !s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff   <= req_data.operation;
         s1_idx_ff  <= idx_sd;
         s1_word_ff <= req_data.has_data ? wd_ext[SLOT_BITS-1:0] : '0;
         s1_dec_ff  <= decision;
         s1_used_ff <= used_ext[4:0];
      end
   end

   assign store_cmd.write_en = s1_advance && s1_dec_ff.alloc_ok;
   assign store_cmd.clear_en = s1_advance && s1_dec_ff.free_ok;

   spfl_slot_store #(
      .SLOTS       (SLOTS),
      .SLOT_BITS   (SLOT_BITS),
      .STORE_DEPTH (SD)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .cmd        (store_cmd),
      .write_slot (grant_slot),
      .write_word (s1_word_ff),
      .access_idx (s1_idx_ff),
      .read_word  (read_word)
   );

   assign slot_ext = {4'b0, grant_slot};

   always_comb begin
      rsp_data_in.granted_index = s1_dec_ff.alloc_ok ? slot_ext[3:0] : 4'b0;
      rsp_data_in.read_data     = (s1_op_ff == OP_READ) ? read_word : 32'b0;
      rsp_data_in.status        = s1_dec_ff.status;
      rsp_data_in.used_count    = s1_used_ff;
   end

   assign rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
